>>> hdl/ipv6_text_address_parser_unit_macros.svh
// Assertion macros shared by the parser unit modules.
// Expects clk and rst_n in the scope of each use.
`ifndef IPV6_TEXT_ADDRESS_PARSER_UNIT_MACROS_SVH
`define IPV6_TEXT_ADDRESS_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define V6AP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define V6AP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/v6ap_pkg.sv
// Types and constants of the IPv6 text address parser unit.
// No dependencies.
package v6ap_pkg;

    localparam int NUM_QUADS  = 8;
    localparam int QUAD_W     = 16;
    localparam int MAX_DIGITS = 4;

    localparam logic [7:0] PREFIX_DEFAULT = 8'd128;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd1;
    localparam logic [2:0] ERR_QUAD_LONG  = 3'd2;
    localparam logic [2:0] ERR_SECOND_GAP = 3'd3;
    localparam logic [2:0] ERR_TOO_FEW    = 3'd4;

    typedef enum logic [2:0] {
        CL_DEC,
        CL_HEXL,
        CL_COLON,
        CL_SLASH,
        CL_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_SLASH,
        PH_DIGITS,
        PH_IGNORE
    } parse_phase_t;

    typedef enum logic {
        BK_RUN,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_token;
    } in_item_t;

    typedef struct packed {
        logic        parse_ok;
        logic [2:0]  error_code;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_length;
    } out_item_t;

    // One classified character as it travels through the queue.
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } cls_item_t;

endpackage

>>> hdl/ipv6_text_address_parser_unit.sv
// Throughput: one character per cycle while the queue has room; each token end adds a final step.
// The final character of a token passes through the queue, then the BK_FINISH state, which loads the result.
// The final step (last quad, zero-gap expansion, error check) holds the parser until the result register is free.
// Reset: asynchronous, active low; clears queue, parser and result valid, quad store left as is.
// Top level of the IPv6 text address parser: front classifier, queue, back parser.
// Depends on v6ap_pkg, v6ap_front, v6ap_queue and v6ap_back.
module ipv6_text_address_parser_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  v6ap_pkg::in_item_t  char_item,
    output logic                result_valid,
    input  logic                result_ready,
    output v6ap_pkg::out_item_t result_item
);

    // Classified characters between the front and the queue.
    logic                push_valid;
    logic                push_ready;
    v6ap_pkg::cls_item_t push_item;

    // Queue head as seen by the parser.
    logic                pop_valid;
    logic                pop_ready;
    v6ap_pkg::cls_item_t pop_item;

    // Classify each accepted character: decimal, hex letter, colon, slash or other.
    v6ap_front u_front
    (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Hold classified items so the front keeps accepting while the back
    // spends its final step on a token end or waits on the result side.
    v6ap_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Parse quads and prefix, then build the 128-bit address into the
    // result register, which parts the parser from the result consumer.
    v6ap_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

>>> hdl/v6ap_front.sv
// Front part: accept characters and classify them for the parser.
// Depends on v6ap_pkg.
module v6ap_front
(
    input  logic               char_valid,
    output logic               char_ready,
    input  v6ap_pkg::in_item_t char_item,
    output logic               push_valid,
    input  logic               push_ready,
    output v6ap_pkg::cls_item_t push_item
);

    logic [7:0] c;

    assign c          = char_item.char_in;
    assign push_valid = char_valid;
    assign char_ready = push_ready;

    always_comb
    begin
        push_item.last  = char_item.end_of_token;
        push_item.digit = 4'd0;
        push_item.cls   = v6ap_pkg::CL_OTHER;
        priority if (c >= 8'h30 && c <= 8'h39)
        begin
            push_item.cls   = v6ap_pkg::CL_DEC;
            push_item.digit = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // a-f and A-F share the low three bits: 1..6 maps to 10..15
            push_item.cls   = v6ap_pkg::CL_HEXL;
            push_item.digit = 4'(4'd9 + {1'b0, c[2:0]});
        end
        else if (c == 8'h3A)
        begin
            push_item.cls = v6ap_pkg::CL_COLON;
        end
        else if (c == 8'h2F)
        begin
            push_item.cls = v6ap_pkg::CL_SLASH;
        end
        else
        begin
            push_item.cls = v6ap_pkg::CL_OTHER;
        end
    end

endmodule

>>> hdl/v6ap_queue.sv
// Short queue of classified characters between front and back parts.
// Depends on v6ap_pkg and the unit's assertion macros.
`include "ipv6_text_address_parser_unit_macros.svh"

module v6ap_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  v6ap_pkg::cls_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output v6ap_pkg::cls_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    v6ap_pkg::cls_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[head_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(tail_reg + 1'b1);
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(head_reg + 1'b1);
        end
        unique case ({push, pop})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_item;
        end
    end

    `V6AP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count over depth")
    `V6AP_ASSERT_NEXT(a_count_grow, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count did not grow on push")

endmodule

>>> hdl/v6ap_back.sv
// Back part: parse classified characters, expand the gap, hold the result.
// Depends on v6ap_pkg and the unit's assertion macros.
`include "ipv6_text_address_parser_unit_macros.svh"

module v6ap_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  v6ap_pkg::cls_item_t pop_item,
    output logic                result_valid,
    input  logic                result_ready,
    output v6ap_pkg::out_item_t result_item
);

    v6ap_pkg::back_state_t  state_reg, state_next;
    v6ap_pkg::parse_phase_t phase_reg, phase_next;

    logic [15:0] cur_quad_reg, cur_quad_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [1:0]  colon_run_reg, colon_run_next;
    logic [3:0]  quad_count_reg, quad_count_next;
    logic [3:0]  gap_reg, gap_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [2:0]  err_reg, err_next;
    logic [15:0] quad_store_reg [v6ap_pkg::NUM_QUADS];

    logic result_valid_reg, result_valid_next;
    v6ap_pkg::out_item_t result_reg;

    logic        step, fin_load;
    logic        is_hex, is_col;
    logic [1:0]  cr;
    logic [2:0]  dc_n;
    logic [15:0] cq_n;
    logic        store_we;

    logic         fin_write, has_gap;
    logic [3:0]   cnt, nz;
    logic [4:0]   gap_end;
    logic [127:0] flat, shifted, expanded;
    logic [2:0]   fin_err;
    v6ap_pkg::out_item_t fin_item;

    // ---------------- control FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            v6ap_pkg::BK_RUN:
                if (pop_valid && pop_item.last) state_next = v6ap_pkg::BK_FINISH;
            v6ap_pkg::BK_FINISH:
                if (!result_valid_reg || result_ready) state_next = v6ap_pkg::BK_RUN;
            default:
                state_next = v6ap_pkg::BK_RUN;
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        fin_load  = 1'b0;
        unique case (state_reg)
            v6ap_pkg::BK_RUN:    pop_ready = 1'b1;
            v6ap_pkg::BK_FINISH: fin_load  = !result_valid_reg || result_ready;
            default:             pop_ready = 1'b0;
        endcase
    end

    assign step = pop_valid && pop_ready;

    // ---------------- per-character parse ----------------
    always_comb
    begin
        phase_next       = phase_reg;
        cur_quad_next    = cur_quad_reg;
        digit_count_next = digit_count_reg;
        colon_run_next   = colon_run_reg;
        quad_count_next  = quad_count_reg;
        gap_next         = gap_reg;
        prefix_next      = prefix_reg;
        err_next         = err_reg;
        store_we         = 1'b0;
        is_hex = (pop_item.cls == v6ap_pkg::CL_DEC) || (pop_item.cls == v6ap_pkg::CL_HEXL);
        is_col = (pop_item.cls == v6ap_pkg::CL_COLON) && (colon_run_reg != 2'd2);
        cr     = is_col ? 2'(colon_run_reg + 2'd1) : 2'd0;
        dc_n   = is_hex ? 3'(digit_count_reg + 3'd1) : digit_count_reg;
        cq_n   = is_hex ? {cur_quad_reg[11:0], pop_item.digit} : cur_quad_reg;

        if (step && err_reg == v6ap_pkg::ERR_NONE)
        begin
            unique case (phase_reg)
                v6ap_pkg::PH_ADDR:
                begin
                    priority if (!is_hex && !is_col)
                    begin
                        phase_next = (pop_item.cls == v6ap_pkg::CL_SLASH) ?
                                     v6ap_pkg::PH_SLASH : v6ap_pkg::PH_IGNORE;
                    end
                    else if (quad_count_reg >= 4'(v6ap_pkg::NUM_QUADS))
                    begin
                        err_next = v6ap_pkg::ERR_TOO_MANY;
                    end
                    else if (is_hex && digit_count_reg >= 3'(v6ap_pkg::MAX_DIGITS))
                    begin
                        err_next = v6ap_pkg::ERR_QUAD_LONG;
                    end
                    else if (cr == 2'd2 && gap_reg < 4'(v6ap_pkg::NUM_QUADS))
                    begin
                        err_next = v6ap_pkg::ERR_SECOND_GAP;
                    end
                    else
                    begin
                        colon_run_next = cr;
                        if (cr == 2'd2) gap_next = quad_count_reg;
                        // a colon after digits closes the quad
                        if (cr != 2'd0 && dc_n != 3'd0)
                        begin
                            store_we         = 1'b1;
                            quad_count_next  = 4'(quad_count_reg + 4'd1);
                            cur_quad_next    = '0;
                            digit_count_next = '0;
                        end
                        else
                        begin
                            cur_quad_next    = cq_n;
                            digit_count_next = dc_n;
                        end
                    end
                end
                v6ap_pkg::PH_SLASH, v6ap_pkg::PH_DIGITS:
                begin
                    if (pop_item.cls == v6ap_pkg::CL_DEC)
                    begin
                        prefix_next = (phase_reg == v6ap_pkg::PH_SLASH) ?
                                      {4'd0, pop_item.digit} :
                                      8'({prefix_reg, 3'd0} + {prefix_reg, 1'b0}
                                         + {4'd0, pop_item.digit});
                        phase_next  = v6ap_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = v6ap_pkg::PH_IGNORE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // close the token once the result is loaded
        if (fin_load)
        begin
            phase_next       = v6ap_pkg::PH_ADDR;
            cur_quad_next    = '0;
            digit_count_next = '0;
            colon_run_next   = '0;
            quad_count_next  = '0;
            gap_next         = 4'(v6ap_pkg::NUM_QUADS);
            prefix_next      = v6ap_pkg::PREFIX_DEFAULT;
            err_next         = v6ap_pkg::ERR_NONE;
        end
    end

    // ---------------- end of token: last quad, gap expansion ----------------
    always_comb
    begin
        fin_write = (err_reg == v6ap_pkg::ERR_NONE) && (digit_count_reg != 3'd0)
                    && (quad_count_reg < 4'(v6ap_pkg::NUM_QUADS));
        cnt       = fin_write ? 4'(quad_count_reg + 4'd1) : quad_count_reg;
        has_gap   = gap_reg < 4'(v6ap_pkg::NUM_QUADS);
        nz        = 4'(4'(v6ap_pkg::NUM_QUADS) - cnt);
        gap_end   = 5'({1'b0, gap_reg} + {1'b0, nz});
        for (int i = 0; i < v6ap_pkg::NUM_QUADS; i++)
        begin
            flat[127 - 16 * i -: 16] = (fin_write && quad_count_reg[2:0] == 3'(i)) ?
                                       cur_quad_reg : quad_store_reg[i];
        end
        shifted = flat >> {nz, 4'd0};
        for (int i = 0; i < v6ap_pkg::NUM_QUADS; i++)
        begin
            priority if (!has_gap || 4'(i) < gap_reg)
                expanded[127 - 16 * i -: 16] = flat[127 - 16 * i -: 16];
            else if (5'(i) < gap_end)
                expanded[127 - 16 * i -: 16] = '0;
            else
                expanded[127 - 16 * i -: 16] = shifted[127 - 16 * i -: 16];
        end
        priority if (err_reg != v6ap_pkg::ERR_NONE)
            fin_err = err_reg;
        else if (!has_gap && cnt < 4'(v6ap_pkg::NUM_QUADS))
            fin_err = v6ap_pkg::ERR_TOO_FEW;
        else
            fin_err = v6ap_pkg::ERR_NONE;

        fin_item.parse_ok      = (fin_err == v6ap_pkg::ERR_NONE);
        fin_item.error_code    = fin_err;
        fin_item.addr_high     = fin_item.parse_ok ? expanded[127:64] : '0;
        fin_item.addr_low      = fin_item.parse_ok ? expanded[63:0] : '0;
        fin_item.prefix_length = fin_item.parse_ok ? prefix_reg : '0;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (fin_load)          result_valid_next = 1'b1;
        else if (result_ready) result_valid_next = 1'b0;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= v6ap_pkg::BK_RUN;
            phase_reg        <= v6ap_pkg::PH_ADDR;
            cur_quad_reg     <= '0;
            digit_count_reg  <= '0;
            colon_run_reg    <= '0;
            quad_count_reg   <= '0;
            gap_reg          <= 4'(v6ap_pkg::NUM_QUADS);
            prefix_reg       <= v6ap_pkg::PREFIX_DEFAULT;
            err_reg          <= v6ap_pkg::ERR_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            cur_quad_reg     <= cur_quad_next;
            digit_count_reg  <= digit_count_next;
            colon_run_reg    <= colon_run_next;
            quad_count_reg   <= quad_count_next;
            gap_reg          <= gap_next;
            prefix_reg       <= prefix_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            quad_store_reg[quad_count_reg[2:0]] <= cq_n;
        end
        if (fin_load)
        begin
            result_reg <= fin_item;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    `V6AP_ASSERT_NOW(a_err_zero, result_valid_reg && !result_reg.parse_ok, result_reg.addr_high == '0 && result_reg.addr_low == '0 && result_reg.prefix_length == '0, "error result carries payload")
    `V6AP_ASSERT_NOW(a_ok_code, result_valid_reg, result_reg.parse_ok == (result_reg.error_code == v6ap_pkg::ERR_NONE), "parse_ok disagrees with error_code")
    `V6AP_ASSERT_NEXT(a_token_clear, fin_load, quad_count_reg == '0 && err_reg == v6ap_pkg::ERR_NONE && phase_reg == v6ap_pkg::PH_ADDR, "token state not cleared")
    `V6AP_ASSERT_NOW(a_quad_bound, 1'b1, quad_count_reg <= 4'(v6ap_pkg::NUM_QUADS), "quad count over eight")

endmodule

>>> dv/tb_ipv6_text_address_parser_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for ipv6_text_address_parser_unit: directed tokens, then random ones.
// Every result is checked against its typed-in value or a cycle-free parser predictor kept in this file.
// Depends on v6ap_pkg and the parser unit RTL.
module tb_ipv6_text_address_parser_unit;

    // Run sizing
    localparam int RANDOM_CHARS     = 1020;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 300;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    logic                clk;
    logic                rst_n;
    logic                char_valid;
    logic                char_ready;
    v6ap_pkg::in_item_t  char_item;
    logic                result_valid;
    logic                result_ready;
    v6ap_pkg::out_item_t result_item;

    ipv6_text_address_parser_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // ------------------------------------------------------------------
    // Parser predictor state: one token in flight, cleared when it closes.
    // The quad store keeps its contents across tokens, like the hardware.
    // ------------------------------------------------------------------
    logic [15:0]            quad_mem [v6ap_pkg::NUM_QUADS];
    logic [15:0]            quad_acc;
    logic [2:0]             digits_seen;
    logic [1:0]             colons_seen;
    logic [3:0]             quads_done;
    logic [3:0]             gap_at;
    v6ap_pkg::parse_phase_t phase;
    logic [7:0]             prefix_acc;
    logic [2:0]             first_error;

    // Parse results still owed by the block, oldest first
    v6ap_pkg::out_item_t    parse_results_due[$];
    int                     error_count;

    // Characters of the token being built, and the directed token table
    logic [7:0]             token_chars[$];
    string                  dir_text[$];
    bit                     dir_typed[$];
    v6ap_pkg::out_item_t    dir_expect[$];

    // Coordination between the character source and the result sink
    bit           hold_request;
    bit           quiet_tail;
    int           send_gap_pct;
    int           chars_accepted;

    function automatic void clear_token_state();
        quad_acc    = '0;
        digits_seen = '0;
        colons_seen = '0;
        quads_done  = '0;
        gap_at      = 4'(v6ap_pkg::NUM_QUADS);
        phase       = v6ap_pkg::PH_ADDR;
        prefix_acc  = v6ap_pkg::PREFIX_DEFAULT;
        first_error = v6ap_pkg::ERR_NONE;
    endfunction

    // Address phase: hex digits, single colons and one '::'. Anything else
    // ends the address; a slash moves on to the prefix length.
    function automatic void parse_addr_char(logic [7:0] ch);
        logic [4:0] nib;
        nib = 5'd16;
        if (ch >= CH_0 && ch <= CH_9)
            nib = 5'(ch - CH_0);
        else if (ch >= CH_LA && ch <= CH_LF)
            nib = 5'(ch - CH_LA + 8'd10);
        else if (ch >= CH_UA && ch <= CH_UF)
            nib = 5'(ch - CH_UA + 8'd10);
        else if (ch == CH_COLON && colons_seen < 2)
            colons_seen++;
        else
        begin
            phase = (ch == CH_SLASH) ? v6ap_pkg::PH_SLASH : v6ap_pkg::PH_IGNORE;
            return;
        end
        if (quads_done >= v6ap_pkg::NUM_QUADS)
        begin
            first_error = v6ap_pkg::ERR_TOO_MANY;
            return;
        end
        if (nib < 16)
        begin
            if (digits_seen >= v6ap_pkg::MAX_DIGITS)
            begin
                first_error = v6ap_pkg::ERR_QUAD_LONG;
                return;
            end
            quad_acc    = {quad_acc[11:0], nib[3:0]};
            colons_seen = '0;
            digits_seen++;
        end
        if (colons_seen == 2)
        begin
            if (gap_at < v6ap_pkg::NUM_QUADS)
            begin
                first_error = v6ap_pkg::ERR_SECOND_GAP;
                return;
            end
            gap_at = quads_done;
        end
        // A colon after digits closes the quad
        if (colons_seen > 0 && digits_seen > 0)
        begin
            quad_mem[quads_done[2:0]] = quad_acc;
            quads_done++;
            quad_acc    = '0;
            digits_seen = '0;
        end
    endfunction

    // Prefix phase: decimal digits accumulate modulo 256, anything else stops it
    function automatic void parse_prefix_char(logic [7:0] ch);
        if (ch >= CH_0 && ch <= CH_9)
        begin
            prefix_acc = (phase == v6ap_pkg::PH_SLASH) ? 8'(ch - CH_0)
                                             : 8'(prefix_acc * 8'd10 + (ch - CH_0));
            phase = v6ap_pkg::PH_DIGITS;
        end
        else
            phase = v6ap_pkg::PH_IGNORE;
    endfunction

    // Close the token: flush the open quad, expand the gap, check the count
    function automatic v6ap_pkg::out_item_t close_token();
        logic [15:0]         q [v6ap_pkg::NUM_QUADS];
        int                  cnt;
        int                  nz;
        v6ap_pkg::out_item_t res;
        res = '0;
        if (first_error == v6ap_pkg::ERR_NONE)
        begin
            if (digits_seen > 0 && quads_done < v6ap_pkg::NUM_QUADS)
            begin
                quad_mem[quads_done[2:0]] = quad_acc;
                quads_done++;
            end
            cnt = quads_done;
            if (gap_at < v6ap_pkg::NUM_QUADS && cnt <= v6ap_pkg::NUM_QUADS)
            begin
                nz = v6ap_pkg::NUM_QUADS - cnt;
                for (int i = 0; i < v6ap_pkg::NUM_QUADS; i++)
                begin
                    if (i < gap_at)
                        q[i] = quad_mem[i];
                    else if (i < gap_at + nz)
                        q[i] = '0;
                    else
                        q[i] = quad_mem[i - nz];
                end
                cnt = v6ap_pkg::NUM_QUADS;
            end
            else
            begin
                for (int i = 0; i < v6ap_pkg::NUM_QUADS; i++)
                    q[i] = quad_mem[i];
            end
            if (cnt < v6ap_pkg::NUM_QUADS)
                first_error = v6ap_pkg::ERR_TOO_FEW;
        end
        if (first_error == v6ap_pkg::ERR_NONE)
        begin
            res.parse_ok      = 1'b1;
            res.error_code    = v6ap_pkg::ERR_NONE;
            res.addr_high     = {q[0], q[1], q[2], q[3]};
            res.addr_low      = {q[4], q[5], q[6], q[7]};
            res.prefix_length = prefix_acc;
        end
        else
            res.error_code = first_error;
        clear_token_state();
        return res;
    endfunction

    // Advance the predictor by one accepted character; 1 when a result is due
    function automatic bit step_parser(v6ap_pkg::in_item_t it,
                                       output v6ap_pkg::out_item_t res);
        res = '0;
        if (first_error == v6ap_pkg::ERR_NONE)
        begin
            if (phase == v6ap_pkg::PH_ADDR)
                parse_addr_char(it.char_in);
            else if (phase == v6ap_pkg::PH_SLASH || phase == v6ap_pkg::PH_DIGITS)
                parse_prefix_char(it.char_in);
        end
        if (!it.end_of_token)
            return 1'b0;
        res = close_token();
        return 1'b1;
    endfunction

    function automatic v6ap_pkg::out_item_t ok_result(logic [63:0] hi, logic [63:0] lo,
                                                      logic [7:0] pfx);
        return '{parse_ok: 1'b1, error_code: v6ap_pkg::ERR_NONE, addr_high: hi,
                 addr_low: lo, prefix_length: pfx};
    endfunction

    function automatic v6ap_pkg::out_item_t err_result(logic [2:0] code);
        return '{parse_ok: 1'b0, error_code: code, addr_high: '0, addr_low: '0,
                 prefix_length: '0};
    endfunction

    function automatic void add_row(string text, bit typed, v6ap_pkg::out_item_t want);
        dir_text.push_back(text);
        dir_typed.push_back(typed);
        dir_expect.push_back(want);
    endfunction

    // ------------------------------------------------------------------
    // Random token construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_digit_char(logic [3:0] v);
        if (v < 10)
            return CH_0 + 8'(v);
        return (($urandom_range(0, 1) == 1) ? CH_LA : CH_UA) + 8'(v - 4'd10);
    endfunction

    function automatic void push_colons(int n);
        repeat (n) token_chars.push_back(CH_COLON);
    endfunction

    // Mostly well-formed addresses with random content; the rest are broken
    // on purpose (too many quads, long quad, second gap, too few quads,
    // triple colon, a corrupted byte) or pure byte noise.
    function automatic void build_random_token();
        int kind;
        int nq;
        int gap_pos;
        int long_idx;
        int extra_gap;
        int sep;
        int ndig;
        bit use_gap;
        bit triple;
        bit corrupt;
        token_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 8)) token_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        use_gap   = $urandom_range(0, 1);
        nq        = use_gap ? $urandom_range(0, 7) : v6ap_pkg::NUM_QUADS;
        long_idx  = -1;
        extra_gap = -1;
        triple    = 1'b0;
        corrupt   = 1'b0;
        if (kind >= 68)
        begin
            case ($urandom_range(0, 5))
                0: nq = nq + $urandom_range(1, 2);
                1:
                begin
                    if (nq == 0)
                        nq = 1;
                    long_idx = $urandom_range(0, nq - 1);
                end
                2:
                begin
                    use_gap   = 1'b1;
                    nq        = $urandom_range(2, 6);
                    extra_gap = $urandom_range(1, nq - 1);
                end
                3:
                begin
                    use_gap = 1'b0;
                    nq      = $urandom_range(1, 7);
                end
                4:
                begin
                    use_gap = 1'b1;
                    triple  = 1'b1;
                end
                default: corrupt = 1'b1;
            endcase
        end
        gap_pos = $urandom_range(0, nq);
        // Occasional lone leading colon
        if (!(use_gap && gap_pos == 0) && $urandom_range(0, 19) == 0)
            push_colons(1);
        for (int i = 0; i < nq; i++)
        begin
            sep = (i > 0) ? 1 : 0;
            if (use_gap && i == gap_pos)
                sep = triple ? 3 : 2;
            else if (i == extra_gap)
                sep = 2;
            push_colons(sep);
            ndig = (i == long_idx) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            repeat (ndig) token_chars.push_back(hex_digit_char(4'($urandom_range(0, 15))));
        end
        if (use_gap && gap_pos == nq)
            push_colons(triple ? 3 : 2);
        else if ($urandom_range(0, 19) == 0)
            push_colons(1);
        if ($urandom_range(0, 99) < 40)
        begin
            token_chars.push_back(CH_SLASH);
            repeat ($urandom_range(0, 4))
                token_chars.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3)) token_chars.push_back(8'($urandom_range(0, 255)));
        if (corrupt)
            token_chars[$urandom_range(0, token_chars.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Character source
    // ------------------------------------------------------------------

    // Offer every character of token_chars in turn; the last one closes the
    // token. Hold valid and payload until the handshake, and log the expected
    // result on acceptance (typed-in value for directed rows that carry one).
    task automatic send_token(input bit typed, input v6ap_pkg::out_item_t typed_res);
        v6ap_pkg::in_item_t  it;
        v6ap_pkg::out_item_t predicted;
        send_gap_pct = quiet_tail ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30));
        for (int k = 0; k < token_chars.size(); k++)
        begin
            if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
            begin
                char_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            it.char_in      = token_chars[k];
            it.end_of_token = (k == token_chars.size() - 1);
            char_item  <= it;
            char_valid <= 1'b1;
            @(posedge clk);
            while (!char_ready)
                @(posedge clk);
            chars_accepted++;
            if (step_parser(it, predicted))
                parse_results_due.push_back(typed ? typed_res : predicted);
        end
    endtask

    // Drop valid and wait until the block owes nothing, then let it settle
    task automatic wait_for_results();
        char_valid <= 1'b0;
        while (parse_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        error_count++;
    endfunction

    function automatic void compare_parse_result(v6ap_pkg::out_item_t got);
        v6ap_pkg::out_item_t want;
        if (parse_results_due.size() == 0)
        begin
            $display("%0t: result with none expected, actual %h", $time, got);
            error_count++;
            return;
        end
        want = parse_results_due.pop_front();
        if (got.parse_ok !== want.parse_ok)
            note_mismatch("parse_ok", 64'(want.parse_ok), 64'(got.parse_ok));
        if (got.error_code !== want.error_code)
            note_mismatch("error_code", 64'(want.error_code), 64'(got.error_code));
        if (got.addr_high !== want.addr_high)
            note_mismatch("addr_high", want.addr_high, got.addr_high);
        if (got.addr_low !== want.addr_low)
            note_mismatch("addr_low", want.addr_low, got.addr_low);
        if (got.prefix_length !== want.prefix_length)
            note_mismatch("prefix_length", 64'(want.prefix_length), 64'(got.prefix_length));
    endfunction

    // Sample the handshake on the pre-edge values, then pick ready for the
    // next cycle: short random stalls, one long hold-off on request, and
    // none at all in the tail of the run.
    initial
    begin : result_sink
        int stall_left;
        bit hold_taken;
        stall_left   = 0;
        hold_taken   = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                compare_parse_result(result_item);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 99) < 8)
                stall_left = $urandom_range(1, 13);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random tokens, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int random_start;
        bit paused;
        rst_n          = 1'b0;
        char_valid     = 1'b0;
        char_item      = '0;
        hold_request   = 1'b0;
        quiet_tail     = 1'b0;
        send_gap_pct   = 0;
        chars_accepted = 0;
        error_count    = 0;
        paused         = 1'b0;
        clear_token_state();

        // Extremes and error codes carry their result; the rest go to the predictor
        add_row("::", 1'b1, ok_result('0, '0, 8'd128));
        add_row("1:2:3:4:5:6:7:8", 1'b1,
                ok_result(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 8'd128));
        add_row("ffff:FFFF:ffff:FFFF:ffff:FFFF:ffff:FFFF/255", 1'b1, ok_result('1, '1, 8'd255));
        add_row("0:0:0:0:0:0:0:0", 1'b1, ok_result('0, '0, 8'd128));
        add_row("::/0", 1'b1, ok_result('0, '0, 8'd0));
        add_row("::/", 1'b1, ok_result('0, '0, 8'd128));
        add_row("1:2:3:4:5:6:7:8:9", 1'b1, err_result(v6ap_pkg::ERR_TOO_MANY));
        add_row("12345::", 1'b1, err_result(v6ap_pkg::ERR_QUAD_LONG));
        add_row("1::2::3", 1'b1, err_result(v6ap_pkg::ERR_SECOND_GAP));
        add_row("1:2:3", 1'b1, err_result(v6ap_pkg::ERR_TOO_FEW));
        add_row("x", 1'b1, err_result(v6ap_pkg::ERR_TOO_FEW));
        add_row("::/300", 1'b0, '0);
        add_row(":1:2:3:4:5:6:7:8", 1'b0, '0);
        add_row("1:2:3:4:5:6:7:8:", 1'b0, '0);
        add_row("1:::2", 1'b0, '0);
        add_row("1:2:3:4:5:6:7::", 1'b0, '0);
        add_row("1::2:3:4:5:6:7:8", 1'b0, '0);
        add_row("1:2:3:4:5:6:7:8::", 1'b0, '0);
        add_row("2001:DB8:aBcD::/64", 1'b0, '0);
        add_row("fe80::1%eth0/9", 1'b0, '0);
        add_row("::ffff:1.2.3.4", 1'b0, '0);
        add_row("::/12x3", 1'b0, '0);
        add_row("ab::cd/99999", 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < dir_text.size(); r++)
        begin
            token_chars.delete();
            for (int k = 0; k < dir_text[r].len(); k++)
                token_chars.push_back(dir_text[r][k]);
            send_token(dir_typed[r], dir_expect[r]);
        end

        random_start = chars_accepted;
        while (chars_accepted - random_start < RANDOM_CHARS)
        begin
            // A quarter in: ask the sink for a long hold-off so the block backs up
            if (chars_accepted - random_start >= RANDOM_CHARS / 4)
                hold_request = 1'b1;
            // Halfway: pause the source until every result is back
            if (!paused && chars_accepted - random_start >= RANDOM_CHARS / 2)
            begin
                paused = 1'b1;
                wait_for_results();
            end
            // Last stretch runs with no idling on either side
            if (chars_accepted - random_start >= (RANDOM_CHARS * 85) / 100)
                quiet_tail = 1'b1;
            build_random_token();
            send_token(1'b0, '0);
        end

        wait_for_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> ipv6_text_address_parser_unit.f
+incdir+hdl
hdl/v6ap_pkg.sv
hdl/v6ap_front.sv
hdl/v6ap_queue.sv
hdl/v6ap_back.sv
hdl/ipv6_text_address_parser_unit.sv
dv/tb_ipv6_text_address_parser_unit.sv
